[hw/rtl/pulse_rate_meter_hysteresis_core_assert.svh]
// Assertion macros shared by the pulse rate meter RTL.
`ifndef PULSE_RATE_METER_HYSTERESIS_CORE_ASSERT_SVH
`define PULSE_RATE_METER_HYSTERESIS_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PRMH_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pulse rate meter: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define PRMH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pulse rate meter: next-cycle check failed");

`endif

[hw/rtl/prmh_pkg.sv]
// Shared types, constants and codes of the pulse rate meter.
package prmh_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int TIME_IN_W  = 32;
    localparam int RATE_W     = 16;
    localparam int ALERT_W    = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int TIME_W_DEF = 32;

    // One quotient bit is resolved per divider step.
    localparam int DIV_STEPS  = RATE_W;
    localparam int CNT_W      = $clog2(DIV_STEPS);

    localparam logic [RATE_W-1:0] RATE_NUMERATOR = 16'd60000;

    localparam logic [SAMPLE_W-1:0] UPPER_RST = 12'd1023;
    localparam logic [SAMPLE_W-1:0] LOWER_RST = 12'd620;
    localparam logic [SAMPLE_W-1:0] FLOOR_RST = 12'd3700;
    localparam logic [RATE_W-1:0]   HIGH_RST  = 16'd100;
    localparam logic [RATE_W-1:0]   LOW_RST   = 16'd60;

    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VALID_FLOOR     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_HIGH_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_LOW_LIMIT  = 3'd4;

    typedef enum logic [ALERT_W-1:0] {
        ALERT_NONE = 2'd0,
        ALERT_HIGH = 2'd1,
        ALERT_LOW  = 2'd2
    } t_alert;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic div_step;
        logic load_result;
    } t_dp_cmd;

endpackage

[hw/rtl/prmh_req_if.sv]
// Request channel: one sensor sample and its timestamp.
interface prmh_req_if
    import prmh_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [SAMPLE_W-1:0]  sample;
    logic [TIME_IN_W-1:0] time_ms;

    modport source (output valid, sample, time_ms, input ready);
    modport sink   (input valid, sample, time_ms, output ready);
endinterface

[hw/rtl/prmh_rsp_if.sv]
// Response channel: rate in beats per minute and the alert code.
interface prmh_rsp_if
    import prmh_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [RATE_W-1:0]  rate_bpm;
    logic [ALERT_W-1:0] rate_alert;

    modport source (output valid, rate_bpm, rate_alert, input ready);
    modport sink   (input valid, rate_bpm, rate_alert, output ready);
endinterface

[hw/rtl/pulse_rate_meter_hysteresis_core.sv]
// Heart-rate meter with threshold hysteresis: one rate and alert per sample request.
// Each request passes through the intake, 16 steps of the restoring divider that forms
// 60000 / interval one quotient bit per cycle, and the load of the output register. A new
// request is taken once the previous one has moved into the output register, even if
// that result is not yet taken. The output register only stalls the block when it is
// still full at load time, and the block then waits in the load state until it is taken.
// A beat is a rise above the upper threshold while armed; a sample below the lower
// threshold re-arms. The rate saturates at 60000 while the beat interval is zero and
// is 0 for samples under the valid floor. Timestamps wrap modulo 2^TIME_WIDTH.
module pulse_rate_meter_hysteresis_core
    import prmh_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_W_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    prmh_req_if.sink              i_req,
    prmh_rsp_if.source            o_rsp
);

    `include "pulse_rate_meter_hysteresis_core_assert.svh"

    t_dp_cmd w_cmd;

    prmh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_out_ready (o_rsp.ready),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .o_cmd       (w_cmd)
    );

    prmh_dp #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_sample     (i_req.sample),
        .i_time_ms    (i_req.time_ms),
        .o_rate_bpm   (o_rsp.rate_bpm),
        .o_rate_alert (o_rsp.rate_alert)
    );

    `PRMH_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_cmd.accept, !i_req.ready)
    `PRMH_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, w_cmd.load_result, !o_rsp.valid || o_rsp.ready)
    `PRMH_ASSERT_NEXT(a_load_shows, i_clk, i_rst_n, w_cmd.load_result, o_rsp.valid)
    `PRMH_ASSERT_IMP(a_high_alert_rate, i_clk, i_rst_n, o_rsp.valid && (o_rsp.rate_alert == ALERT_HIGH), (o_rsp.rate_bpm != '0) && (o_rsp.rate_bpm <= RATE_NUMERATOR))

endmodule

[hw/rtl/prmh_ctrl.sv]
// Controller: sequences request intake, the divider steps and the result load.
module prmh_ctrl
    import prmh_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_out_ready,
    output logic    o_in_ready,
    output logic    o_out_valid,
    output t_dp_cmd o_cmd
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             w_out_free;
    logic             w_last_step;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_last_step = (r_cnt == CNT_W'(DIV_STEPS - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_last_step) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready        = 1'b0;
        o_cmd.accept      = 1'b0;
        o_cmd.div_step    = 1'b0;
        o_cmd.load_result = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            ST_DONE: begin
                o_cmd.load_result = w_out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_cnt = r_cnt;
        if (o_cmd.accept) begin
            n_cnt = '0;
        end else if (o_cmd.div_step) begin
            n_cnt = r_cnt + 1'b1;
        end
    end

    // The result register is released when taken and refilled at the end of a request.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_result) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

[hw/rtl/prmh_dp.sv]
// Datapath: configuration, beat detection state, restoring divider and result register.
module prmh_dp
    import prmh_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_W_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [SAMPLE_W-1:0]   i_sample,
    input  logic [TIME_IN_W-1:0]  i_time_ms,
    output logic [RATE_W-1:0]     o_rate_bpm,
    output logic [ALERT_W-1:0]    o_rate_alert
);

    // Compare width covers both the shifted remainder and the divisor.
    localparam int CMP_W = (TIME_WIDTH > RATE_W + 1) ? TIME_WIDTH : RATE_W + 1;

    logic [SAMPLE_W-1:0]   r_upper, r_lower, r_floor;
    logic [RATE_W-1:0]     r_high_lim, r_low_lim;

    logic                  r_blocked, n_blocked;
    logic                  r_first_seen, n_first_seen;
    logic [TIME_WIDTH-1:0] r_last_time, n_last_time;
    logic [TIME_WIDTH-1:0] r_interval, n_interval;
    logic                  r_low_sample;

    logic [RATE_W-1:0]     r_num, r_rem, r_quot;
    logic [RATE_W-1:0]     r_rate_bpm;
    logic [ALERT_W-1:0]    r_rate_alert;

    logic [TIME_WIDTH-1:0] w_now;
    logic                  w_beat;
    logic [RATE_W:0]       w_trial;
    logic [CMP_W-1:0]      w_trial_ext, w_div_ext, w_diff;
    logic                  w_ge;
    logic [RATE_W-1:0]     w_rate;
    t_alert                w_alert;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper    <= UPPER_RST;
            r_lower    <= LOWER_RST;
            r_floor    <= FLOOR_RST;
            r_high_lim <= HIGH_RST;
            r_low_lim  <= LOW_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_UPPER_THRESHOLD: r_upper    <= i_cfg_data[SAMPLE_W-1:0];
                CFG_LOWER_THRESHOLD: r_lower    <= i_cfg_data[SAMPLE_W-1:0];
                CFG_VALID_FLOOR:     r_floor    <= i_cfg_data[SAMPLE_W-1:0];
                CFG_RATE_HIGH_LIMIT: r_high_lim <= i_cfg_data;
                CFG_RATE_LOW_LIMIT:  r_low_lim  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign w_now  = TIME_WIDTH'(i_time_ms);
    assign w_beat = (i_sample > r_upper) && !r_blocked;

    // The beat test comes first; a sample under the lower threshold re-arms afterwards.
    always_comb begin
        n_blocked    = r_blocked;
        n_first_seen = r_first_seen;
        n_last_time  = r_last_time;
        n_interval   = r_interval;
        if (w_beat) begin
            if (r_first_seen) begin
                n_interval = w_now - r_last_time;
            end
            n_first_seen = 1'b1;
            n_last_time  = w_now;
            n_blocked    = 1'b1;
        end
        if (i_sample < r_lower) begin
            n_blocked = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blocked    <= 1'b0;
            r_first_seen <= 1'b0;
            r_last_time  <= '0;
            r_interval   <= '0;
        end else if (i_cmd.accept) begin
            r_blocked    <= n_blocked;
            r_first_seen <= n_first_seen;
            r_last_time  <= n_last_time;
            r_interval   <= n_interval;
        end
    end

    // Restoring division of the constant numerator by the beat interval.
    assign w_trial     = {r_rem, r_num[RATE_W-1]};
    assign w_trial_ext = CMP_W'(w_trial);
    assign w_div_ext   = CMP_W'(r_interval);
    assign w_diff      = w_trial_ext - w_div_ext;
    assign w_ge        = (w_trial_ext >= w_div_ext);

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_low_sample <= (i_sample < r_floor);
            r_num        <= RATE_NUMERATOR;
            r_rem        <= '0;
            r_quot       <= '0;
        end else if (i_cmd.div_step) begin
            r_num  <= {r_num[RATE_W-2:0], 1'b0};
            r_rem  <= w_ge ? w_diff[RATE_W-1:0] : w_trial[RATE_W-1:0];
            r_quot <= {r_quot[RATE_W-2:0], w_ge};
        end
    end

    always_comb begin
        if (r_low_sample) begin
            w_rate = '0;
        end else if (r_interval == '0) begin
            w_rate = RATE_NUMERATOR;
        end else begin
            w_rate = r_quot;
        end
    end

    always_comb begin
        priority if (w_rate > r_high_lim) begin
            w_alert = ALERT_HIGH;
        end else if (w_rate < r_low_lim) begin
            w_alert = ALERT_LOW;
        end else begin
            w_alert = ALERT_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_result) begin
            r_rate_bpm   <= w_rate;
            r_rate_alert <= w_alert;
        end
    end

    assign o_rate_bpm   = r_rate_bpm;
    assign o_rate_alert = r_rate_alert;

endmodule
